// File: src/rrsw_pkg.sv
package rrsw_pkg;
    localparam int NumTasks = 16;
    localparam int IdW = $clog2(NumTasks);
    localparam int CntW = $clog2(NumTasks + 1);
    localparam int CauseW = 32;

    typedef enum logic [2:0] {
        REQ_RUN    = 3'd0,
        REQ_YIELD  = 3'd1,
        REQ_SLEEP  = 3'd2,
        REQ_EXIT   = 3'd3,
        REQ_WAKEUP = 3'd4
    } t_req;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_TASK = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NO_CURRENT = 2'd3;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [IdW-1:0]    task_id;
        logic [CauseW-1:0] wait_cause;
    } t_in;

    typedef struct packed {
        logic [IdW-1:0]  current_task;
        logic            current_valid;
        logic [1:0]      status;
        logic [CntW-1:0] woken_count;
        logic [CntW-1:0] runnable_count;
    } t_out;
endpackage

// File: src/rrsw_if.sv
interface rrsw_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/rrsw_ram.sv
// Simple dual-port RAM, registered read.
module rrsw_ram #(
    parameter int Depth = 16,
    parameter int Width = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: src/round_robin_sleep_wakeup_scheduler_top.sv
// Run goes from decode to the output state; yield, sleep and exit also pass the pop
// state when the deque head is popped (one deque RAM read); wakeup visits scan-wait
// and scan once per waiting entry. One item at a time.
// Result held in an output register until taken; input ready only when idle with no
// result pending, so the next item is accepted in the cycle after the result is taken.
// Synchronous active-low reset empties deque and wait list, clears current.
module round_robin_sleep_wakeup_scheduler_top
    import rrsw_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    rrsw_if.sink   i_req,
    rrsw_if.source o_res
);
    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_POP, S_SCAN, S_SCAN_WAIT, S_OUT} t_state;

    t_state              r_state;
    t_in                 r_in;
    logic [IdW-1:0]      r_head;
    logic [CntW-1:0]     r_rcnt;
    logic [CntW-1:0]     r_wcnt;
    logic [IdW-1:0]      r_cur;
    logic                r_curv;
    logic [1:0]          r_status;
    logic [CntW-1:0]     r_woken;
    logic [CntW-1:0]     r_idx;
    logic [CntW-1:0]     r_keep;
    logic                r_requeue;
    logic [IdW-1:0]      r_old;
    logic                r_ovalid;
    t_out                r_out;

    // Deque RAM
    logic            dq_we;
    logic [IdW-1:0]  dq_waddr, dq_wdata, dq_raddr, dq_rdata;
    // Wait list RAM: id and cause together
    logic                  wl_we;
    logic [IdW-1:0]        wl_waddr, wl_raddr;
    logic [IdW+CauseW-1:0] wl_wdata, wl_rdata;

    rrsw_ram #(.Depth(NumTasks), .Width(IdW)) u_dq (
        .i_clk(i_clk), .i_we(dq_we), .i_waddr(dq_waddr), .i_wdata(dq_wdata),
        .i_raddr(dq_raddr), .o_rdata(dq_rdata));
    rrsw_ram #(.Depth(NumTasks), .Width(IdW + CauseW)) u_wl (
        .i_clk(i_clk), .i_we(wl_we), .i_waddr(wl_waddr), .i_wdata(wl_wdata),
        .i_raddr(wl_raddr), .o_rdata(wl_rdata));

    logic [IdW-1:0]    tail;
    logic [IdW-1:0]    head_m1;
    logic [IdW-1:0]    w_id;
    logic [CauseW-1:0] w_cause;
    logic              match;

    assign tail    = r_head + r_rcnt[IdW-1:0];
    assign head_m1 = r_head - IdW'(1);
    assign w_id    = wl_rdata[IdW+CauseW-1:CauseW];
    assign w_cause = wl_rdata[CauseW-1:0];
    assign match   = (w_cause == r_in.wait_cause);
    assign dq_raddr = r_head;
    assign wl_raddr = r_idx[IdW-1:0];

    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    // Memory write ports
    always_comb begin
        dq_we = 1'b0;
        dq_waddr = tail;
        dq_wdata = r_in.task_id;
        wl_we = 1'b0;
        wl_waddr = r_wcnt[IdW-1:0];
        wl_wdata = {r_cur, r_in.wait_cause};
        unique case (r_state)
            S_DECODE: begin
                if (r_in.req_type == REQ_RUN && r_curv && r_rcnt < CntW'(NumTasks)) begin
                    dq_we = 1'b1;
                end
                if (r_in.req_type == REQ_SLEEP && r_curv && r_wcnt < CntW'(NumTasks)) begin
                    wl_we = 1'b1;
                end
            end
            S_POP: begin
                // tail computed with popped head already counted
                dq_we = r_requeue;
                dq_waddr = r_head + r_rcnt[IdW-1:0];
                dq_wdata = r_old;
            end
            S_SCAN: begin
                if (match && r_rcnt < CntW'(NumTasks)) begin
                    dq_we = 1'b1;
                    dq_waddr = head_m1;
                    dq_wdata = w_id;
                end else begin
                    wl_we = 1'b1;
                    wl_waddr = r_keep[IdW-1:0];
                    wl_wdata = wl_rdata;
                end
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_rcnt   <= '0;
            r_wcnt   <= '0;
            r_cur    <= '0;
            r_curv   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_in      <= i_req.data;
                        r_status  <= ST_OK;
                        r_woken   <= '0;
                        r_requeue <= 1'b0;
                        r_state   <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_state <= S_OUT;
                    priority if (r_in.req_type == REQ_RUN) begin
                        if (!r_curv) begin
                            r_cur  <= r_in.task_id;
                            r_curv <= 1'b1;
                        end else if (r_rcnt >= CntW'(NumTasks)) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_rcnt <= r_rcnt + CntW'(1);
                        end
                    end else if (r_in.req_type == REQ_YIELD
                                 || r_in.req_type == REQ_SLEEP
                                 || r_in.req_type == REQ_EXIT) begin
                        if (!r_curv) begin
                            r_status <= ST_NO_CURRENT;
                        end else if (r_in.req_type == REQ_SLEEP
                                     && r_wcnt >= CntW'(NumTasks)) begin
                            r_status <= ST_FULL;
                        end else begin
                            if (r_in.req_type == REQ_SLEEP) begin
                                r_wcnt <= r_wcnt + CntW'(1);
                            end
                            if (r_rcnt != '0) begin
                                r_requeue <= (r_in.req_type == REQ_YIELD);
                                r_old     <= r_cur;
                                r_state   <= S_POP;
                            end else if (r_in.req_type != REQ_YIELD) begin
                                r_status <= ST_NO_TASK;
                                r_cur    <= '0;
                                r_curv   <= 1'b0;
                            end
                        end
                    end else if (r_in.req_type == REQ_WAKEUP) begin
                        r_idx  <= '0;
                        r_keep <= '0;
                        if (r_wcnt != '0) begin
                            r_state <= S_SCAN_WAIT;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_POP: begin
                    // dq_rdata holds head entry now; pop and maybe push back
                    r_cur  <= dq_rdata;
                    r_curv <= 1'b1;
                    r_head <= r_head + IdW'(1);
                    if (!r_requeue) begin
                        r_rcnt <= r_rcnt - CntW'(1);
                    end
                    r_state <= S_OUT;
                end
                S_SCAN_WAIT: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (match && r_rcnt < CntW'(NumTasks)) begin
                        r_head  <= head_m1;
                        r_rcnt  <= r_rcnt + CntW'(1);
                        r_woken <= r_woken + CntW'(1);
                    end else begin
                        if (match) begin
                            r_status <= ST_FULL;
                        end
                        r_keep <= r_keep + CntW'(1);
                    end
                    r_idx <= r_idx + CntW'(1);
                    if (r_idx + CntW'(1) >= r_wcnt) begin
                        r_wcnt <= (match && r_rcnt < CntW'(NumTasks))
                                  ? r_keep : r_keep + CntW'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SCAN_WAIT;
                    end
                end
                S_OUT: begin
                    r_out.current_task   <= r_cur;
                    r_out.current_valid  <= r_curv;
                    r_out.status         <= r_status;
                    r_out.woken_count    <= r_woken;
                    r_out.runnable_count <= r_rcnt;
                    r_ovalid             <= 1'b1;
                    r_state              <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: src/rrsw_checker.sv
module rrsw_checker
    import rrsw_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input t_out out_data
);
    // Result stalled holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    // No new item while a result waits
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !(in_valid && in_ready))
        else $error("item accepted with result pending");
    // Runnable never exceeds capacity
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data.runnable_count <= CntW'(NumTasks))
        else $error("deque count too large");
    // No current task reads as zero
    a_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.current_valid |-> out_data.current_task == '0)
        else $error("idle current task not zero");
    // Nothing woken unless ok or full
    a_woke: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.woken_count != '0 |->
        (out_data.status == ST_OK || out_data.status == ST_FULL))
        else $error("woken with bad status");
endmodule

bind round_robin_sleep_wakeup_scheduler_top rrsw_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_req.valid), .in_ready(i_req.ready),
    .out_valid(o_res.valid), .out_ready(o_res.ready), .out_data(o_res.data));
